// ===== rtl/nmac_pkg.sv =====
package nmac_pkg;

    localparam int WEIGHT_W = 14;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = WEIGHT_W + SAMPLE_W;
    localparam int FRAC_W   = 10;                   // one = 1024
    localparam int TERM_W   = PROD_W - FRAC_W;
    localparam int SUM_W    = 27;
    localparam int RESULT_W = SUM_W + 1;
    localparam int BIAS_W   = 14;
    localparam int SIG_W    = FRAC_W;               // sigmoid output 0..1023
    localparam int REM_W    = RESULT_W;             // |x| and |x|+1024 fit here
    localparam int STEP_W   = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SIG_W - 1);
    localparam logic [REM_W-1:0]  ONE_SCALE = REM_W'(1 << FRAC_W);

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_BIAS    = 1'b0;
    localparam logic REG_SIGMOID = 1'b1;

    typedef struct packed {
        logic signed [BIAS_W-1:0] bias;
        logic                     apply_sigmoid;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DSTART,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/nmac_in_if.sv =====
interface nmac_in_if;
    import nmac_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_term;

    modport source (output valid, output weight_value, output sample_value,
                    output last_term, input ready);
    modport sink   (input valid, input weight_value, input sample_value,
                    input last_term, output ready);
endinterface

// ===== rtl/nmac_out_if.sv =====
interface nmac_out_if;
    import nmac_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] result_value;

    modport source (output valid, output result_value, input ready);
    modport sink   (input valid, input result_value, output ready);
endinterface

// ===== rtl/fixed_point_neuron_mac_sigmoid.sv =====
// a pair is multiplied first, then truncated and accumulated
// a last pair in raw mode passes the accumulate and done states into the output register
// a last pair in sigmoid mode also passes the divide start state and the divider's ten steps
// ready only while the sequencer idles, so a new pair waits until the last one is through
// rst_n clears the sum, the sequencer and the output valid, bias to 0, sigmoid on
module fixed_point_neuron_mac_sigmoid (
    input  logic                         clk,
    input  logic                         rst_n,
    nmac_in_if.sink                      in_ch,
    nmac_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nmac_pkg::ADDR_W-1:0]  paddr,
    input  logic [nmac_pkg::DATA_W-1:0]  pwdata,
    output logic [nmac_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import nmac_pkg::*;

    cfg_t                       cfg;
    div_stat_t                  div_stat;
    logic [SIG_W-1:0]           div_sig;
    logic                       div_start;

    state_t                     state_reg;
    state_t                     state_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic                       last_reg;
    logic                       last_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [RESULT_W-1:0] x_reg;
    logic signed [RESULT_W-1:0] x_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [RESULT_W-1:0] out_data_reg;
    logic signed [RESULT_W-1:0] out_data_next;

    logic                       in_xfer;
    logic                       out_free;
    logic signed [TERM_W-1:0]   term;
    logic signed [SUM_W-1:0]    sum_acc;

    nmac_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nmac_sig_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (x_reg),
        .stat  (div_stat),
        .sig   (div_sig)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // product / 1024 truncated toward zero
    assign term    = prod_reg[PROD_W-1:FRAC_W]
                   + TERM_W'(prod_reg[PROD_W-1] && (prod_reg[FRAC_W-1:0] != '0));
    assign sum_acc = sum_reg + SUM_W'(term);

    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    prod_next  = PROD_W'(in_ch.weight_value) * PROD_W'(in_ch.sample_value);
                    last_next  = in_ch.last_term;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (last_reg)
                begin
                    x_next     = RESULT_W'(sum_acc) + RESULT_W'(cfg.bias);
                    sum_next   = '0;
                    state_next = cfg.apply_sigmoid ? ST_DSTART : ST_DONE;
                end
                else
                begin
                    sum_next   = sum_acc;
                    state_next = ST_IDLE;
                end
            end
            ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = cfg.apply_sigmoid ? RESULT_W'({1'b0, div_sig}) : x_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        x_reg        <= x_next;
        out_data_reg <= out_data_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_data_reg;

    a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_ACC)
        else $error("accepted pair did not reach accumulate");

    a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && last_reg) |=> sum_reg == '0)
        else $error("running sum not cleared after last pair");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free && cfg.apply_sigmoid)
            |=> (out_ch.result_value >= 0 && out_ch.result_value < RESULT_W'(1 << SIG_W)))
        else $error("sigmoid result out of range");

endmodule

// ===== rtl/nmac_apb_regs.sv =====
module nmac_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nmac_pkg::ADDR_W-1:0]  paddr,
    input  logic [nmac_pkg::DATA_W-1:0]  pwdata,
    output logic [nmac_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output nmac_pkg::cfg_t               cfg
);
    import nmac_pkg::*;

    logic signed [BIAS_W-1:0] bias_reg;
    logic signed [BIAS_W-1:0] bias_next;
    logic                     sig_reg;
    logic                     sig_next;
    logic                     wr_en;
    logic                     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_comb
    begin
        bias_next = bias_reg;
        sig_next  = sig_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_BIAS:    bias_next = pwdata[BIAS_W-1:0];
                REG_SIGMOID: sig_next  = pwdata[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
            sig_reg  <= 1'b1;
        end
        else
        begin
            bias_reg <= bias_next;
            sig_reg  <= sig_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BIAS:    prdata = DATA_W'(bias_reg);
            REG_SIGMOID: prdata = DATA_W'(sig_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.bias          = bias_reg;
    assign cfg.apply_sigmoid = sig_reg;

endmodule

// ===== rtl/nmac_sig_div.sv =====
module nmac_sig_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [nmac_pkg::RESULT_W-1:0] x,
    output nmac_pkg::div_stat_t                 stat,
    output logic [nmac_pkg::SIG_W-1:0]          sig
);
    import nmac_pkg::*;

    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [REM_W-1:0]  den_reg;
    logic [REM_W-1:0]  den_next;
    logic [SIG_W-1:0]  quo_reg;
    logic [SIG_W-1:0]  quo_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              neg_reg;
    logic              neg_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [REM_W-1:0]  mag;
    logic [REM_W:0]    shifted;
    logic [REM_W:0]    diff;
    logic [SIG_W:0]    biased;

    // |x| of the most negative 28-bit value still fits unsigned
    assign mag     = x[RESULT_W-1] ? REM_W'(-x) : REM_W'(x);
    // quotient is below 1024, so the remainder starts at |x| and ten steps follow
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = mag;
            den_next  = mag + ONE_SCALE;
            quo_next  = '0;
            cnt_next  = '0;
            neg_next  = x[RESULT_W-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[REM_W])
            begin
                rem_next = diff[REM_W-1:0];
                quo_next = {quo_reg[SIG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[REM_W-1:0];
                quo_next = {quo_reg[SIG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    // (q + 1024) / 2 with q signed; the sum is always positive
    assign biased = neg_reg ? (ONE_SCALE[SIG_W:0] - {1'b0, quo_reg})
                            : (ONE_SCALE[SIG_W:0] + {1'b0, quo_reg});
    assign sig    = biased[SIG_W:1];

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
